// ===== design/u8d_pkg.sv =====
`default_nettype none

package u8d_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [20:0] cp_t;
	typedef logic [31:0] key_t;
	typedef logic [1:0]  pend_t;

	localparam cp_t CP_INVALID = 21'h00FFFD;

	localparam logic [6:0] PRINT_LO    = 7'h21;
	localparam logic [6:0] PRINT_HI    = 7'h7E;
	localparam logic [8:0] PRINT_SPAN  = 9'd94;
	localparam logic [8:0] PRINT_SPAN2 = 9'd188;
	localparam logic [8:0] PRINT_SPAN3 = 9'd282;

	// rotate a printable code within 0x21..0x7e by an 8-bit amount
	// offset plus amount is at most 93 + 255, so three compare and subtract steps
	function automatic logic [6:0] u8d_rotate(input logic [6:0] c, input logic [7:0] amt);
		logic [8:0] s;
		logic [8:0] r;
		s = ({2'b00, c} - {2'b00, PRINT_LO}) + {1'b0, amt};
		if (s >= PRINT_SPAN3) begin
			r = s - PRINT_SPAN3;
		end else if (s >= PRINT_SPAN2) begin
			r = s - PRINT_SPAN2;
		end else if (s >= PRINT_SPAN) begin
			r = s - PRINT_SPAN;
		end else begin
			r = s;
		end
		return r[6:0] + PRINT_LO;
	endfunction

	function automatic key_t u8d_xorshift(input key_t k);
		key_t a;
		key_t b;
		a = k ^ (k << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

`default_nettype wire

// ===== design/u8d_byte_if.sv =====
`default_nettype none

interface u8d_byte_if;
	import u8d_pkg::*;

	logic  valid;
	logic  ready;
	byte_t in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== design/u8d_cp_if.sv =====
`default_nettype none

interface u8d_cp_if;
	import u8d_pkg::*;

	logic valid;
	logic ready;
	cp_t  cp_data;

	modport source (output valid, output cp_data, input ready);
	modport sink (input valid, input cp_data, output ready);
endinterface

`default_nettype wire

// ===== design/utf8_decode_with_scramble.sv =====
// a byte accepted into the input register has its code point, if it completes one,
// loaded into the output register unless that one holds a result not yet taken
// throughput: one byte per cycle; the input stalls only when the byte in the input
// register has a result and the output register holds one that is not taken
// reset (arst_n low, asynchronous): pending sequence, scramble key and all valids clear
// a cfg_we write reloads the running key from cfg_wdata
`default_nettype none

module utf8_decode_with_scramble (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire u8d_pkg::key_t cfg_wdata,
	u8d_byte_if.sink          byte_ch,
	u8d_cp_if.source          cp_ch
);
	import u8d_pkg::*;

	logic  v_s1;
	byte_t byte_s1;

	cp_t   part_q;
	pend_t pend_q;
	key_t  key_q;

	logic  out_v_q;
	cp_t   out_cp_q;

	logic  has_res;
	cp_t   res_cp;
	cp_t   part_n;
	pend_t pend_n;
	key_t  key_n;
	logic  adv;
	logic  out_load;
	cp_t   cont_val;

	assign cont_val = {part_q[14:0], byte_s1[5:0]};

	always_comb begin
		has_res = 1'b0;
		res_cp  = CP_INVALID;
		part_n  = part_q;
		pend_n  = pend_q;
		key_n   = key_q;
		if (!byte_s1[7]) begin
			// ascii leaves a pending sequence alone
			has_res = 1'b1;
			res_cp  = {14'd0, byte_s1[6:0]};
			if (key_q != '0) begin
				if (byte_s1[6:0] >= PRINT_LO && byte_s1[6:0] <= PRINT_HI) begin
					res_cp = {14'd0, u8d_rotate(byte_s1[6:0], key_q[7:0])};
				end
				key_n = u8d_xorshift(key_q);
			end
		end else if (!byte_s1[6]) begin
			has_res = 1'b1;
			if (pend_q != '0) begin
				pend_n = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					res_cp = cont_val;
					part_n = '0;
				end else begin
					has_res = 1'b0;
					part_n  = cont_val;
				end
			end
		end else if (pend_q == '0) begin
			if (!byte_s1[5]) begin
				part_n = {16'd0, byte_s1[4:0]};
				pend_n = 2'd1;
			end else if (!byte_s1[4]) begin
				part_n = {17'd0, byte_s1[3:0]};
				pend_n = 2'd2;
			end else if (!byte_s1[3]) begin
				part_n = {18'd0, byte_s1[2:0]};
				pend_n = 2'd3;
			end else begin
				has_res = 1'b1;
			end
		end else begin
			// lead byte where a continuation was due: drop the sequence
			has_res = 1'b1;
			part_n  = '0;
			pend_n  = '0;
		end
	end

	assign adv           = v_s1 && (!has_res || !out_v_q || cp_ch.ready);
	assign byte_ch.ready = !v_s1 || adv;
	assign out_load      = !out_v_q || cp_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			part_q  <= '0;
			pend_q  <= '0;
			key_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (byte_ch.ready) begin
				v_s1 <= byte_ch.valid;
			end
			if (cfg_we) begin
				key_q <= cfg_wdata;
			end else if (adv) begin
				key_q <= key_n;
			end
			if (adv) begin
				part_q <= part_n;
				pend_q <= pend_n;
			end
			if (out_load) begin
				out_v_q <= adv && has_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1 <= byte_ch.in_byte;
		end
		if (out_load && adv && has_res) begin
			out_cp_q <= res_cp;
		end
	end

	assign cp_ch.valid   = out_v_q;
	assign cp_ch.cp_data = out_cp_q;

endmodule

`default_nettype wire

// ===== design/u8d_chk.sv =====
`default_nettype none

module u8d_chk (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_ready,
	input wire               out_valid,
	input wire               out_ready,
	input wire u8d_pkg::cp_t cp_data
);
	import u8d_pkg::*;

	// output register is empty while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(cp_data))
		else $error("stalled result changed");

	// input only stalls behind a full output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with output empty");

	// a fresh result must come from an accepted item that passed the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching item");

endmodule

bind utf8_decode_with_scramble u8d_chk u_u8d_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_ch.valid),
	.in_ready  (byte_ch.ready),
	.out_valid (cp_ch.valid),
	.out_ready (cp_ch.ready),
	.cp_data   (cp_ch.cp_data)
);

`default_nettype wire
